// ===== rtl/core/qema_pkg.sv =====
// Shared types, field widths and codes of the angle smoothing filter.
package qema_pkg;

  localparam int unsigned SHIFT_MAX_DEF       = 12;
  localparam int unsigned FRACTION_BITS_DEF   = 8;
  localparam int unsigned ANGLE_LIMIT_DEF     = 1800;

  localparam int unsigned REQ_W       = 2;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TC_W        = 16;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned JUMP_W      = 12;

  localparam logic [TC_W-1:0]     TC_RESET     = 16'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
  localparam logic [JUMP_W-1:0]   JUMP_RESET   = 12'd50;

  typedef enum logic [REQ_W-1:0] {
    REQ_UPDATE = 2'd0,
    REQ_RELOAD = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP       = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]           req_type;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] sample_deci;
  } item_t;

  typedef struct packed {
    logic reloaded;
    logic held;
  } flags_t;

endpackage

// ===== rtl/core/qema_if.sv =====
// Channel interfaces: sample requests in, filtered results out, register writes.
interface qema_in_if;
  import qema_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic                       sample_valid;
  logic signed [SAMPLE_W-1:0] sample_deci;
  modport source (output valid, req_type, sample_valid, sample_deci, input ready);
  modport sink   (input valid, req_type, sample_valid, sample_deci, output ready);
endinterface

interface qema_out_if;
  import qema_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       value_valid;
  logic signed [SAMPLE_W-1:0] value_deci;
  logic                       reloaded;
  logic                       held;
  modport source (output valid, value_valid, value_deci, reloaded, held, input ready);
  modport sink   (input valid, value_valid, value_deci, reloaded, held, output ready);
endinterface

interface qema_cfg_if;
  import qema_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/qema_shift_sel.sv =====
// Iterative search for the shift whose realized time constant is nearest the wanted one.
module qema_shift_sel #(
  parameter int unsigned SHIFT_MAX = qema_pkg::SHIFT_MAX_DEF,
  parameter int unsigned SHIFT_W   = $clog2(SHIFT_MAX + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic [qema_pkg::TC_W-1:0]     tc_i,
  input  logic [qema_pkg::PERIOD_W-1:0] period_i,
  output logic                          busy_o,
  output logic [SHIFT_W-1:0]            shift_o
);
  import qema_pkg::*;

  localparam int unsigned PW = PERIOD_W + SHIFT_MAX + 1;

  logic               busy_q;
  logic [SHIFT_W-1:0] k_q, best_q;
  logic [PW-1:0]      best_err_q;

  logic [PW-1:0]      period_ext, tc_ext, prod, realized, err;
  logic [PW:0]        rnd;
  logic               better;

  // period * (2^(k+1) - 1) is a shift and a subtract.
  always_comb begin
    period_ext = PW'(period_i);
    tc_ext     = PW'(tc_i);
    prod       = (period_ext << ({1'b0, k_q} + 1'b1)) - period_ext;
    rnd        = {1'b0, prod} + 1'b1;
    realized   = rnd[PW:1];
    err        = (realized > tc_ext) ? (realized - tc_ext) : (tc_ext - realized);
    // Strict compare keeps the smaller shift on a tie.
    better     = (k_q == '0) || (err < best_err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      k_q        <= '0;
      best_q     <= '0;
      best_err_q <= '0;
    end else if (restart_i) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (busy_q) begin
      if (better) begin
        best_q     <= k_q;
        best_err_q <= err;
      end
      if (k_q == SHIFT_W'(SHIFT_MAX)) begin
        busy_q <= 1'b0;
      end else begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  assign busy_o  = busy_q;
  assign shift_o = best_q;

endmodule

// ===== rtl/core/qema_datapath.sv =====
// Filter state and the enabled update of accumulator, held sample, primed flag and result flags.
module qema_datapath #(
  parameter int unsigned FRACTION_BITS = qema_pkg::FRACTION_BITS_DEF,
  parameter int unsigned SHIFT_W       = 4,
  parameter int unsigned ACC_W         = qema_pkg::SAMPLE_W + FRACTION_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_en_i,
  input  qema_pkg::item_t             item_i,
  input  logic [qema_pkg::JUMP_W-1:0] jump_i,
  input  logic [SHIFT_W-1:0]          shift_i,
  output logic                        primed_o,
  output logic signed [ACC_W-1:0]     acc_o,
  output qema_pkg::flags_t            flags_o
);
  import qema_pkg::*;

  localparam int unsigned DW = ACC_W + 1;

  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [SAMPLE_W-1:0] held_q, held_d;
  logic                       primed_q, primed_d;
  flags_t                     flags_q, flags_d;

  logic signed [ACC_W-1:0]    sample_fx, target;
  logic signed [DW-1:0]       diff, acc_ext;
  logic [DW-1:0]              mag, jump_fx, step_raw, step;
  logic signed [DW-1:0]       acc_move;

  always_comb begin
    sample_fx = {item_i.sample_deci, {FRACTION_BITS{1'b0}}};
    target    = item_i.sample_valid ? sample_fx : {held_q, {FRACTION_BITS{1'b0}}};
    acc_ext   = {acc_q[ACC_W-1], acc_q};
    diff      = {target[ACC_W-1], target} - acc_ext;
    mag       = diff[DW-1] ? DW'(-diff) : DW'(diff);
    jump_fx   = DW'({jump_i, {FRACTION_BITS{1'b0}}});
    step_raw  = mag >> shift_i;
    step      = (step_raw == '0) ? DW'(1) : step_raw;
    acc_move  = diff[DW-1] ? (acc_ext - $signed(step)) : (acc_ext + $signed(step));

    acc_d    = acc_q;
    held_d   = held_q;
    primed_d = primed_q;
    flags_d  = '0;
    unique case (req_e'(item_i.req_type))
      REQ_CLEAR: begin
        acc_d    = '0;
        held_d   = '0;
        primed_d = 1'b0;
      end
      REQ_RELOAD: begin
        if (item_i.sample_valid) begin
          held_d           = item_i.sample_deci;
          acc_d            = sample_fx;
          primed_d         = 1'b1;
          flags_d.reloaded = 1'b1;
        end
      end
      REQ_UPDATE: begin
        flags_d.held = !item_i.sample_valid;
        if (item_i.sample_valid) begin
          held_d = item_i.sample_deci;
        end
        if (!primed_q) begin
          // The first valid sample loads the accumulator directly.
          if (item_i.sample_valid) begin
            acc_d            = sample_fx;
            primed_d         = 1'b1;
            flags_d.reloaded = 1'b1;
          end
        end else if (mag >= jump_fx) begin
          acc_d            = target;
          flags_d.reloaded = 1'b1;
        end else if (diff != '0) begin
          acc_d = acc_move[ACC_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      held_q   <= '0;
      primed_q <= 1'b0;
      flags_q  <= '0;
    end else if (step_en_i) begin
      acc_q    <= acc_d;
      held_q   <= held_d;
      primed_q <= primed_d;
      flags_q  <= flags_d;
    end
  end

  assign primed_o = primed_q;
  assign acc_o    = acc_q;
  assign flags_o  = flags_q;

endmodule

// ===== rtl/core/qema_round.sv =====
// Rounds the accumulator half away from zero to tenths of a degree, clamps it and gives zero while unprimed.
module qema_round #(
  parameter int unsigned FRACTION_BITS    = qema_pkg::FRACTION_BITS_DEF,
  parameter int unsigned ANGLE_LIMIT_DECI = qema_pkg::ANGLE_LIMIT_DEF,
  parameter int unsigned ACC_W            = qema_pkg::SAMPLE_W + FRACTION_BITS
) (
  input  logic                                 primed_i,
  input  logic signed [ACC_W-1:0]              acc_i,
  output logic signed [qema_pkg::SAMPLE_W-1:0] value_o
);
  import qema_pkg::*;

  localparam int unsigned DW = ACC_W + 1;
  localparam logic [31:0] LIMIT = 32'(ANGLE_LIMIT_DECI);

  logic signed [DW-1:0] ext;
  logic                 neg;
  logic [DW-1:0]        mag, sum, whole;
  logic [31:0]          mag_clamped, signed_val;

  always_comb begin
    ext         = {acc_i[ACC_W-1], acc_i};
    neg         = acc_i[ACC_W-1];
    mag         = neg ? DW'(-ext) : DW'(ext);
    sum         = mag + (DW'(1) << (FRACTION_BITS - 1));
    whole       = sum >> FRACTION_BITS;
    mag_clamped = (32'(whole) > LIMIT) ? LIMIT : 32'(whole);
    signed_val  = neg ? (32'd0 - mag_clamped) : mag_clamped;
    value_o     = primed_i ? signed_val[SAMPLE_W-1:0] : '0;
  end

endmodule

// ===== rtl/core/q8_ema_filter_jump_reload_core.sv =====
// Top level of the angle smoothing filter with jump reload.
// Takes one request per clock cycle while no shift search runs and the output does not
// stall, and returns one result for each: the request is captured in an input
// register, the filter state is updated into the result register, and a new request is
// taken while a result waits if the input register is empty. After reset and after every
// write to time_constant_ms or sample_period_ms, shifts 0 to SHIFT_MAX are searched, one
// candidate per cycle, with requests held off. Register writes are always taken.
module q8_ema_filter_jump_reload_core #(
  parameter int unsigned SHIFT_MAX        = qema_pkg::SHIFT_MAX_DEF,
  parameter int unsigned FRACTION_BITS    = qema_pkg::FRACTION_BITS_DEF,
  parameter int unsigned ANGLE_LIMIT_DECI = qema_pkg::ANGLE_LIMIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  qema_in_if.sink           in_i,
  qema_out_if.source        out_o,
  qema_cfg_if.sink          cfg_i
);
  import qema_pkg::*;

  localparam int unsigned SHIFT_W = $clog2(SHIFT_MAX + 1);
  localparam int unsigned ACC_W   = SAMPLE_W + FRACTION_BITS;

  logic [TC_W-1:0]     tc_q;
  logic [PERIOD_W-1:0] period_q;
  logic [JUMP_W-1:0]   jump_q;
  logic                cfg_write, shift_restart;

  item_t               item_q;
  logic                item_valid_q, out_valid_q;
  logic                in_accept, step_en;

  logic                shift_busy;
  logic [SHIFT_W-1:0]  shift;
  logic                primed;
  logic signed [ACC_W-1:0] acc;
  flags_t              flags;
  logic signed [SAMPLE_W-1:0] value;

  // Configuration registers.
  assign cfg_i.ready   = 1'b1;
  assign cfg_write     = cfg_i.valid;
  assign shift_restart = cfg_write &&
                         ((cfg_i.index == CFG_TIME_CONST) || (cfg_i.index == CFG_PERIOD));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q     <= TC_RESET;
      period_q <= PERIOD_RESET;
      jump_q   <= JUMP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_i.index)
        CFG_TIME_CONST: tc_q     <= cfg_i.data[TC_W-1:0];
        CFG_PERIOD:     period_q <= cfg_i.data[PERIOD_W-1:0];
        CFG_JUMP:       jump_q   <= cfg_i.data[JUMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The state update fires when a captured request can move into a free result slot.
  assign step_en    = item_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !shift_busy && (!item_valid_q || step_en);
  assign in_accept  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= in_accept || (item_valid_q && !step_en);
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.req_type     <= in_i.req_type;
      item_q.sample_valid <= in_i.sample_valid;
      item_q.sample_deci  <= in_i.sample_deci;
    end
  end

  qema_shift_sel #(
    .SHIFT_MAX (SHIFT_MAX),
    .SHIFT_W   (SHIFT_W)
  ) u_shift_sel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (shift_restart),
    .tc_i      (tc_q),
    .period_i  (period_q),
    .busy_o    (shift_busy),
    .shift_o   (shift)
  );

  qema_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .SHIFT_W       (SHIFT_W),
    .ACC_W         (ACC_W)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (item_q),
    .jump_i    (jump_q),
    .shift_i   (shift),
    .primed_o  (primed),
    .acc_o     (acc),
    .flags_o   (flags)
  );

  // The result is read from the state registers, which hold still while it waits.
  qema_round #(
    .FRACTION_BITS    (FRACTION_BITS),
    .ANGLE_LIMIT_DECI (ANGLE_LIMIT_DECI),
    .ACC_W            (ACC_W)
  ) u_round (
    .primed_i (primed),
    .acc_i    (acc),
    .value_o  (value)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.value_valid = primed;
  assign out_o.value_deci  = value;
  assign out_o.reloaded    = flags.reloaded;
  assign out_o.held        = flags.held;

endmodule
